/* rtl/core/two_sensor_direction_counter_core_assert.svh */
// Assertion macros of the direction counter checker.
// No dependencies; included by the checker file.
`ifndef TWO_SENSOR_DIRECTION_COUNTER_CORE_ASSERT_SVH
`define TWO_SENSOR_DIRECTION_COUNTER_CORE_ASSERT_SVH

// same-cycle implication
`define TSDC_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("tsdc check failed");

// next-cycle implication
`define TSDC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("tsdc check failed");

`endif

/* rtl/core/tsdc_pkg.sv */
// Shared types and constants of the two-sensor direction counter.
// No dependencies; used by every other file of the block but the assertion header.
package tsdc_pkg;

	localparam int unsigned TIME_WIDTH_DEF  = 32;
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	localparam int unsigned OPCODE_W = 2;
	localparam int unsigned STAMP_W  = 32;
	localparam int unsigned REPORT_W = 16;
	localparam int unsigned TICKS_W  = 16;

	localparam logic [OPCODE_W-1:0] OP_EDGE_A  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_EDGE_B  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_COLLECT = 2'd2;

	localparam logic [TICKS_W-1:0] HOLDOFF_DEFAULT = 16'd500;
	localparam logic [TICKS_W-1:0] IDLE_DEFAULT    = 16'd2000;
	localparam logic               ACC_EN_DEFAULT  = 1'b0;

	// APB map: register index in paddr[3:2]
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W  = 2;
	localparam logic [REG_IDX_W-1:0] REG_HOLDOFF    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SILENCE    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACCUMULATE = 2'd2;

	typedef enum logic [1:0] {
		EXP_NONE = 2'd0,
		EXP_A    = 2'd1,
		EXP_B    = 2'd2
	} expect_t;

	typedef struct packed {
		logic [TICKS_W-1:0] holdoff_ticks;
		logic [TICKS_W-1:0] silence_ticks;
		logic               accumulate_enable;
	} cfg_t;

	typedef struct packed {
		logic                passage_counted;
		logic                report_valid;
		logic [REPORT_W-1:0] period_count_a;
		logic [REPORT_W-1:0] period_count_b;
		logic [REPORT_W-1:0] total_a;
		logic [REPORT_W-1:0] total_b;
	} result_t;

endpackage

/* rtl/core/tsdc_if.sv */
// Valid/ready channel interfaces for the direction counter: item in, result out.
// Depends on tsdc_pkg for field widths.
interface tsdc_item_if;
	import tsdc_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [STAMP_W-1:0]  timestamp;

	modport source (output valid, output opcode, output timestamp, input ready);
	modport sink   (input valid, input opcode, input timestamp, output ready);
endinterface

interface tsdc_result_if;
	import tsdc_pkg::*;

	logic                valid;
	logic                ready;
	logic                passage_counted;
	logic                report_valid;
	logic [REPORT_W-1:0] period_count_a;
	logic [REPORT_W-1:0] period_count_b;
	logic [REPORT_W-1:0] total_a;
	logic [REPORT_W-1:0] total_b;

	modport source (output valid, output passage_counted, output report_valid,
		output period_count_a, output period_count_b, output total_a, output total_b,
		input ready);
	modport sink (input valid, input passage_counted, input report_valid,
		input period_count_a, input period_count_b, input total_a, input total_b,
		output ready);
endinterface

/* rtl/core/tsdc_apb_regs.sv */
// APB configuration registers of the direction counter.
// Depends on tsdc_pkg (register map, cfg_t).
module tsdc_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tsdc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [tsdc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tsdc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output tsdc_pkg::cfg_t                   cfg
);
	import tsdc_pkg::*;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.holdoff_ticks     <= HOLDOFF_DEFAULT;
			cfg_q.silence_ticks     <= IDLE_DEFAULT;
			cfg_q.accumulate_enable <= ACC_EN_DEFAULT;
		end else if (wr_en) begin
			case (idx)
				REG_HOLDOFF:    cfg_q.holdoff_ticks     <= pwdata[TICKS_W-1:0];
				REG_SILENCE:    cfg_q.silence_ticks     <= pwdata[TICKS_W-1:0];
				REG_ACCUMULATE: cfg_q.accumulate_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_HOLDOFF:    prdata[TICKS_W-1:0] = cfg_q.holdoff_ticks;
			REG_SILENCE:    prdata[TICKS_W-1:0] = cfg_q.silence_ticks;
			REG_ACCUMULATE: prdata[0]           = cfg_q.accumulate_enable;
			default:        prdata              = '0;
		endcase
	end
endmodule

/* rtl/core/tsdc_count_logic.sv */
// Passage state (times, expectation, counts, totals) and the per-beat decision.
// Depends on tsdc_pkg (cfg_t, result_t, opcodes, expect_t).
module tsdc_count_logic #(
	parameter int unsigned TIME_WIDTH  = tsdc_pkg::TIME_WIDTH_DEF,
	parameter int unsigned COUNT_WIDTH = tsdc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [tsdc_pkg::OPCODE_W-1:0]  opcode,
	input  logic [tsdc_pkg::STAMP_W-1:0]   timestamp,
	input  tsdc_pkg::cfg_t                 cfg,
	output tsdc_pkg::result_t              res
);
	import tsdc_pkg::*;

	logic [TIME_WIDTH-1:0]  last_pass_q, last_edge_q;
	expect_t                expected_q;
	logic [COUNT_WIDTH-1:0] count_a_q, count_b_q;
	logic [REPORT_W-1:0]    sum_a_q, sum_b_q;

	logic [TIME_WIDTH+STAMP_W-1:0] now_ext;
	logic [TIME_WIDTH+TICKS_W-1:0] hold_ext, gap_ext;
	logic [COUNT_WIDTH+REPORT_W-1:0] pa_ext, pb_ext;
	logic [TIME_WIDTH-1:0]  now, el_pass, el_edge;
	logic [TICKS_W-1:0]     hold, gap;
	logic [REPORT_W-1:0]    pa, pb, sum_a_nx, sum_b_nx;
	logic                   is_edge, open, stale, match;
	expect_t                mine, other, exp_eff;

	// zero in a ticks register means the default
	assign hold = (cfg.holdoff_ticks == '0) ? HOLDOFF_DEFAULT : cfg.holdoff_ticks;
	assign gap  = (cfg.silence_ticks == '0) ? IDLE_DEFAULT : cfg.silence_ticks;

	assign now_ext  = {{TIME_WIDTH{1'b0}}, timestamp};
	assign hold_ext = {{TIME_WIDTH{1'b0}}, hold};
	assign gap_ext  = {{TIME_WIDTH{1'b0}}, gap};
	assign now      = now_ext[TIME_WIDTH-1:0];

	// wraparound differences
	assign el_pass = now - last_pass_q;
	assign el_edge = now - last_edge_q;

	assign is_edge = (opcode == OP_EDGE_A) || (opcode == OP_EDGE_B);
	assign mine    = (opcode == OP_EDGE_A) ? EXP_A : EXP_B;
	assign other   = (opcode == OP_EDGE_A) ? EXP_B : EXP_A;
	assign open    = el_pass >= hold_ext[TIME_WIDTH-1:0];
	assign stale   = el_edge >= gap_ext[TIME_WIDTH-1:0];
	assign exp_eff = stale ? EXP_NONE : expected_q;
	assign match   = exp_eff == mine;

	assign pa_ext   = {{REPORT_W{1'b0}}, count_a_q};
	assign pb_ext   = {{REPORT_W{1'b0}}, count_b_q};
	assign pa       = pa_ext[REPORT_W-1:0];
	assign pb       = pb_ext[REPORT_W-1:0];
	assign sum_a_nx = sum_a_q + pa;
	assign sum_b_nx = sum_b_q + pb;

	always_comb begin
		res = '0;
		case (opcode)
			OP_EDGE_A, OP_EDGE_B: res.passage_counted = open && match;
			OP_COLLECT: begin
				res.report_valid   = 1'b1;
				res.period_count_a = pa;
				res.period_count_b = pb;
				if (cfg.accumulate_enable) begin
					res.total_a = sum_a_nx;
					res.total_b = sum_b_nx;
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pass_q <= '0;
			last_edge_q <= '0;
			expected_q  <= EXP_NONE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
		end else if (fire) begin
			if (is_edge && open) begin
				last_edge_q <= now;
				if (match) begin
					last_pass_q <= now;
					expected_q  <= EXP_NONE;
					if (opcode == OP_EDGE_A) begin
						count_a_q <= count_a_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
					end else begin
						count_b_q <= count_b_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
					end
				end else begin
					expected_q <= other;
				end
			end else if (opcode == OP_COLLECT) begin
				count_a_q <= '0;
				count_b_q <= '0;
				if (cfg.accumulate_enable) begin
					sum_a_q <= sum_a_nx;
					sum_b_q <= sum_b_nx;
				end
			end
		end
	end
endmodule

/* rtl/core/two_sensor_direction_counter_core.sv */
// Two-sensor direction counter.
// Channels: item (opcode, timestamp) in, result out, both valid/ready; a beat
// moves when valid and ready are high at a rising clk edge. Opcode 0/1 is an
// edge on sensor A/B, 2 collects and clears the period counts, 3 gives an
// all-zero result. Every item gives exactly one result, in order.
// Configuration through APB: holdoff at 0x0, idle gap at 0x4, accumulate
// enable at 0x8; pready is tied high. Write only while no item is in flight.
// Path: an accepted item waits in the input register, then its result is
// registered in the result register and offered from there.
// Throughput: one item per cycle while result.ready is high; the input register
// feeds the passage logic, which decides and updates its state as the beat
// moves into the result register. When result.ready is low the result register
// holds its beat and the input register takes one more item; item.ready drops
// once both are full. Reset (arst_n low) empties both registers, clears counts,
// totals, stored times and the expectation, and restores holdoff 500, idle gap
// 2000 and accumulation off.
module two_sensor_direction_counter_core #(
	parameter int unsigned TIME_WIDTH  = tsdc_pkg::TIME_WIDTH_DEF,
	parameter int unsigned COUNT_WIDTH = tsdc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tsdc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [tsdc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tsdc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	tsdc_item_if.sink                        item,
	tsdc_result_if.source                    result
);
	import tsdc_pkg::*;

	cfg_t                cfg;
	result_t             res, result_q;
	logic                valid_s1, out_valid_q, advance;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [STAMP_W-1:0]  timestamp_s1;

	tsdc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tsdc_count_logic #(
		.TIME_WIDTH  (TIME_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_logic (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.opcode    (opcode_s1),
		.timestamp (timestamp_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// state is updated only when the beat moves into the result register
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			opcode_s1    <= item.opcode;
			timestamp_s1 <= item.timestamp;
		end
		if (advance) begin
			result_q <= res;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.passage_counted = result_q.passage_counted;
	assign result.report_valid    = result_q.report_valid;
	assign result.period_count_a  = result_q.period_count_a;
	assign result.period_count_b  = result_q.period_count_b;
	assign result.total_a         = result_q.total_a;
	assign result.total_b         = result_q.total_b;
endmodule

/* rtl/core/tsdc_checker.sv */
// Port-level checks of the direction counter, bound to the top level.
// Depends on tsdc_pkg and two_sensor_direction_counter_core_assert.svh.
`include "two_sensor_direction_counter_core_assert.svh"

module tsdc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [tsdc_pkg::APB_ADDR_W-1:0]  paddr,
	input logic [tsdc_pkg::APB_DATA_W-1:0]  pwdata,
	input logic [tsdc_pkg::APB_DATA_W-1:0]  prdata,
	input logic                             result_valid,
	input logic                             result_ready,
	input logic                             result_passage_counted,
	input logic                             result_report_valid,
	input logic [tsdc_pkg::REPORT_W-1:0]    result_period_count_a,
	input logic [tsdc_pkg::REPORT_W-1:0]    result_period_count_b,
	input logic [tsdc_pkg::REPORT_W-1:0]    result_total_a,
	input logic [tsdc_pkg::REPORT_W-1:0]    result_total_b
);
	import tsdc_pkg::*;

	// a stalled result beat stays offered
	`TSDC_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid)

	// an edge result and a report never share a beat
	`TSDC_ASSERT_IMPLY(a_one_kind, clk, arst_n, result_valid, !(result_passage_counted && result_report_valid))

	// edge results carry no counts or totals
	`TSDC_ASSERT_IMPLY(a_edge_zero, clk, arst_n, result_valid && !result_report_valid, (result_period_count_a == '0) && (result_period_count_b == '0) && (result_total_a == '0) && (result_total_b == '0))

	// accumulate enable reads back what was just written
	`TSDC_ASSERT_IMPLY(a_acc_readback, clk, arst_n, (psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_ACCUMULATE)) ##1 (psel && !pwrite && (paddr[APB_ADDR_W-1:2] == REG_ACCUMULATE)), (prdata[0] == $past(pwdata[0])) && (prdata[APB_DATA_W-1:1] == '0))
endmodule

bind two_sensor_direction_counter_core tsdc_checker u_tsdc_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.psel                   (psel),
	.penable                (penable),
	.pwrite                 (pwrite),
	.paddr                  (paddr),
	.pwdata                 (pwdata),
	.prdata                 (prdata),
	.result_valid           (result.valid),
	.result_ready           (result.ready),
	.result_passage_counted (result.passage_counted),
	.result_report_valid    (result.report_valid),
	.result_period_count_a  (result.period_count_a),
	.result_period_count_b  (result.period_count_b),
	.result_total_a         (result.total_a),
	.result_total_b         (result.total_b)
);
